// ===== rtl/core/hcrp_pkg.sv =====
// shared types, codes and header field tables of the hvcC record parser
package hcrp_pkg;

  localparam int unsigned HdrBytes = 23;
  localparam logic [4:0] HdrLastIdx = 5'(HdrBytes - 1);
  localparam logic [1:0] ClassDrop = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_ATYPE   = 3'd1,
    PH_CNT_HI  = 3'd2,
    PH_CNT_LO  = 3'd3,
    PH_LEN_HI  = 3'd4,
    PH_LEN_LO  = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_DONE    = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_FIELD       = 2'd0,
    KIND_UNIT_BYTE   = 2'd1,
    KIND_EMPTY_UNIT  = 2'd2,
    KIND_STATUS      = 2'd3
  } kind_e;

  // header fields that complete on one header byte
  typedef struct packed {
    logic [2:0] cnt;
    logic [3:0] first;
  } hdr_layout_t;

  // everything one input word produces, expanded later one result at a time
  typedef struct packed {
    kind_e       main_kind;
    logic [2:0]  main_cnt;
    logic [3:0]  first_id;
    logic [31:0] data;
    logic [1:0]  unit_type;
    logic        unit_first;
    logic        unit_last;
    logic        has_status;
    logic        record_ok;
  } run_t;

  function automatic hdr_layout_t hdr_layout(input logic [4:0] idx);
    hdr_layout_t l;
    l = '0;
    case (idx)
      5'd0:  l = '{cnt: 3'd1, first: 4'd0};
      5'd1:  l = '{cnt: 3'd3, first: 4'd1};
      5'd5:  l = '{cnt: 3'd1, first: 4'd4};
      5'd12: l = '{cnt: 3'd1, first: 4'd5};
      5'd14: l = '{cnt: 3'd1, first: 4'd6};
      5'd15: l = '{cnt: 3'd1, first: 4'd7};
      5'd16: l = '{cnt: 3'd1, first: 4'd8};
      5'd17: l = '{cnt: 3'd1, first: 4'd9};
      5'd18: l = '{cnt: 3'd1, first: 4'd10};
      5'd20: l = '{cnt: 3'd1, first: 4'd11};
      5'd21: l = '{cnt: 3'd4, first: 4'd12};
      default: l = '0;
    endcase
    return l;
  endfunction

  // acc holds the latest header bytes, up to four, the newest in the low byte
  function automatic logic [31:0] field_value(input logic [3:0] id, input logic [31:0] acc);
    logic [31:0] v;
    v = '0;
    case (id)
      4'd0:  v = {24'd0, acc[7:0]};
      4'd1:  v = {30'd0, acc[7:6]};
      4'd2:  v = {31'd0, acc[5]};
      4'd3:  v = {27'd0, acc[4:0]};
      4'd4:  v = acc;
      4'd5:  v = {24'd0, acc[7:0]};
      4'd6:  v = {20'd0, acc[11:0]};
      4'd7:  v = {30'd0, acc[1:0]};
      4'd8:  v = {30'd0, acc[1:0]};
      4'd9:  v = {29'd0, acc[2:0]};
      4'd10: v = {29'd0, acc[2:0]};
      4'd11: v = {16'd0, acc[15:0]};
      4'd12: v = {30'd0, acc[7:6]};
      4'd13: v = {29'd0, acc[5:3]};
      4'd14: v = {31'd0, acc[2]};
      default: v = {30'd0, acc[1:0]};
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/hcrp_if.sv =====
// stream interfaces for record words in and parse results out
interface hcrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hcrp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  field_id;
  logic [31:0] field_value;
  logic [1:0]  unit_type;
  logic [7:0]  unit_byte;
  logic        unit_first;
  logic        unit_last;
  logic        record_ok;
  logic        last_of_run;

  modport source (output valid, output result_kind, output field_id, output field_value,
                  output unit_type, output unit_byte, output unit_first, output unit_last,
                  output record_ok, output last_of_run, input ready);
  modport sink (input valid, input result_kind, input field_id, input field_value,
                input unit_type, input unit_byte, input unit_first, input unit_last,
                input record_ok, input last_of_run, output ready);
endinterface

// ===== rtl/core/hcrp_parser.sv =====
// parse state machine: walks header and arrays, describes the results of each word
module hcrp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  output hcrp_pkg::run_t   run_o
);

  hcrp_pkg::phase_e phase_q, phase_d;
  logic [4:0]  idx_q, idx_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  arrays_q, arrays_d;
  logic [15:0] units_q, units_d;
  logic [15:0] bytes_q, bytes_d;
  logic [1:0]  class_q, class_d;

  logic [31:0] acc_sh;
  logic [7:0]  arrays_dec;
  logic [15:0] units_dec;
  logic [15:0] cnt_full;
  logic [15:0] len_full;
  logic [5:0]  ntype;
  hcrp_pkg::phase_e arr_close_phase;
  hcrp_pkg::phase_e unit_close_phase;
  hcrp_pkg::hdr_layout_t lay;
  hcrp_pkg::run_t run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= hcrp_pkg::PH_HEADER;
      idx_q    <= '0;
      acc_q    <= '0;
      arrays_q <= '0;
      units_q  <= '0;
      bytes_q  <= '0;
      class_q  <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      acc_q    <= acc_d;
      arrays_q <= arrays_d;
      units_q  <= units_d;
      bytes_q  <= bytes_d;
      class_q  <= class_d;
    end
  end

  always_comb begin
    acc_sh     = {acc_q[23:0], data_byte_i};
    arrays_dec = arrays_q - 8'd1;
    units_dec  = units_q - 16'd1;
    cnt_full   = {units_q[15:8], data_byte_i};
    len_full   = {bytes_q[15:8], data_byte_i};
    ntype      = data_byte_i[5:0];
    lay        = hcrp_pkg::hdr_layout(idx_q);
    arr_close_phase  = (arrays_dec != 8'd0) ? hcrp_pkg::PH_ATYPE : hcrp_pkg::PH_DONE;
    unit_close_phase = (units_dec != 16'd0) ? hcrp_pkg::PH_LEN_HI : arr_close_phase;

    phase_d  = phase_q;
    idx_d    = idx_q;
    acc_d    = acc_q;
    arrays_d = arrays_q;
    units_d  = units_q;
    bytes_d  = bytes_q;
    class_d  = class_q;
    run      = '0;

    unique case (phase_q)
      hcrp_pkg::PH_HEADER: begin
        run.main_kind = hcrp_pkg::KIND_FIELD;
        run.main_cnt  = lay.cnt;
        run.first_id  = lay.first;
        run.data      = acc_sh;
        acc_d         = acc_sh;
        idx_d         = idx_q + 5'd1;
        if (idx_q >= hcrp_pkg::HdrLastIdx) begin
          arrays_d = data_byte_i;
          phase_d  = (data_byte_i != 8'd0) ? hcrp_pkg::PH_ATYPE : hcrp_pkg::PH_DONE;
          acc_d    = '0;
        end
      end
      hcrp_pkg::PH_ATYPE: begin
        class_d = (ntype >= 6'd32 && ntype <= 6'd34) ? ntype[1:0] : hcrp_pkg::ClassDrop;
        phase_d = hcrp_pkg::PH_CNT_HI;
      end
      hcrp_pkg::PH_CNT_HI: begin
        units_d = {data_byte_i, 8'h00};
        phase_d = hcrp_pkg::PH_CNT_LO;
      end
      hcrp_pkg::PH_CNT_LO: begin
        units_d = cnt_full;
        if (cnt_full == 16'd0) begin
          arrays_d = arrays_dec;
          phase_d  = arr_close_phase;
        end else begin
          phase_d = hcrp_pkg::PH_LEN_HI;
        end
      end
      hcrp_pkg::PH_LEN_HI: begin
        bytes_d = {data_byte_i, 8'h00};
        phase_d = hcrp_pkg::PH_LEN_LO;
      end
      hcrp_pkg::PH_LEN_LO: begin
        bytes_d = len_full;
        if (len_full == 16'd0) begin
          if (class_q != hcrp_pkg::ClassDrop) begin
            run.main_kind = hcrp_pkg::KIND_EMPTY_UNIT;
            run.main_cnt  = 3'd1;
            run.unit_type = class_q;
          end
          units_d = units_dec;
          if (units_dec == 16'd0) arrays_d = arrays_dec;
          phase_d = unit_close_phase;
        end else begin
          acc_d   = 32'd1;
          phase_d = hcrp_pkg::PH_PAYLOAD;
        end
      end
      hcrp_pkg::PH_PAYLOAD: begin
        if (class_q != hcrp_pkg::ClassDrop) begin
          run.main_kind  = hcrp_pkg::KIND_UNIT_BYTE;
          run.main_cnt   = 3'd1;
          run.unit_type  = class_q;
          run.data       = {24'd0, data_byte_i};
          run.unit_first = acc_q[0];
          run.unit_last  = (bytes_q == 16'd1);
        end
        acc_d   = '0;
        bytes_d = bytes_q - 16'd1;
        if (bytes_q == 16'd1) begin
          units_d = units_dec;
          if (units_dec == 16'd0) arrays_d = arrays_dec;
          phase_d = unit_close_phase;
        end
      end
      hcrp_pkg::PH_DONE: begin
        // trailing words are ignored
      end
      default: begin
        phase_d = hcrp_pkg::PH_HEADER;
      end
    endcase

    // end of record: report and start over
    if (last_byte_i) begin
      run.has_status = 1'b1;
      run.record_ok  = (phase_d == hcrp_pkg::PH_DONE);
      phase_d  = hcrp_pkg::PH_HEADER;
      idx_d    = '0;
      acc_d    = '0;
      arrays_d = '0;
      units_d  = '0;
      bytes_d  = '0;
      class_d  = '0;
    end
  end

  assign run_o = run;

endmodule

// ===== rtl/core/hcrp_serializer.sv =====
// result register: holds one word's run of results and hands them out in order
module hcrp_serializer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  hcrp_pkg::run_t   run_i,
  output logic             can_load_o,
  hcrp_out_if.source       out_o
);

  hcrp_pkg::run_t run_q;
  logic       valid_q;
  logic [2:0] pos_q;
  logic [2:0] total;
  logic       at_last;
  logic       in_main;
  logic       take;
  logic [3:0] fid;

  assign total   = run_q.main_cnt + {2'b00, run_q.has_status};
  assign at_last = (pos_q == total - 3'd1);
  assign in_main = (pos_q < run_q.main_cnt);
  assign take    = valid_q && out_o.ready;
  assign fid     = run_q.first_id + {1'b0, pos_q};

  // a new word may enter while the final result of the current run leaves
  assign can_load_o = !valid_q || (take && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else if (can_load_o) begin
      valid_q <= load_i;
      pos_q   <= '0;
    end else if (take) begin
      pos_q <= pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && can_load_o) run_q <= run_i;
  end

  always_comb begin
    out_o.valid       = valid_q;
    out_o.result_kind = hcrp_pkg::KIND_STATUS;
    out_o.field_id    = '0;
    out_o.field_value = '0;
    out_o.unit_type   = '0;
    out_o.unit_byte   = '0;
    out_o.unit_first  = 1'b0;
    out_o.unit_last   = 1'b0;
    out_o.record_ok   = 1'b0;
    out_o.last_of_run = at_last;
    if (in_main) begin
      out_o.result_kind = run_q.main_kind;
      case (run_q.main_kind)
        hcrp_pkg::KIND_FIELD: begin
          out_o.field_id    = fid;
          out_o.field_value = hcrp_pkg::field_value(fid, run_q.data);
        end
        hcrp_pkg::KIND_UNIT_BYTE: begin
          out_o.unit_type  = run_q.unit_type;
          out_o.unit_byte  = run_q.data[7:0];
          out_o.unit_first = run_q.unit_first;
          out_o.unit_last  = run_q.unit_last;
        end
        default: begin
          out_o.unit_type = run_q.unit_type;
        end
      endcase
    end else begin
      out_o.record_ok = run_q.record_ok;
    end
  end

endmodule

// ===== rtl/core/hevc_config_record_parser.sv =====
// top level of the hvcC record parser: parse state machine and result register
// Takes an HEVC decoder configuration record one word (byte) per cycle while the
// result register has room and returns header fields, tagged VPS/SPS/PPS payload
// bytes, empty-unit marks and a final status word. The parse state advances in the
// same cycle a word is accepted and its results go to a result register that hands
// them out one per cycle while the receiver is ready. A word causes 0 to 5 results
// (more than one only on header bytes 1 and 21 and on the word marked last);
// payload streams through at one word per cycle when the output does not stall,
// and the next word is taken in the cycle the final result of the current one
// leaves. last_of_run marks the final result of each word. A word marked last
// also returns the parser to its reset state, so the next word opens a new record.
module hevc_config_record_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcrp_in_if.sink    in_i,
  hcrp_out_if.source out_o
);

  hcrp_pkg::run_t run;
  logic can_load;
  logic accept;
  logic has_items;

  assign in_i.ready = can_load;
  assign accept     = in_i.valid && can_load;
  assign has_items  = (run.main_cnt != 3'd0) || run.has_status;

  hcrp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .run_o       (run)
  );

  hcrp_serializer u_serializer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept && has_items),
    .run_i      (run),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

// ===== dv/hcrp_tb_pkg.sv =====
// expected-result model and scoreboard for the hvcC record parser testbench
package hcrp_tb_pkg;
  import hcrp_pkg::*;

  localparam logic [5:0] NalVps = 6'd32;
  localparam logic [5:0] NalPps = 6'd34;

  typedef enum logic [3:0] {
    FLD_VERSION, FLD_PROFILE_SPACE, FLD_TIER, FLD_PROFILE_IDC, FLD_COMPAT_FLAGS,
    FLD_LEVEL_IDC, FLD_MIN_SEG, FLD_PARALLELISM, FLD_CHROMA_FMT, FLD_LUMA_DEPTH,
    FLD_CHROMA_DEPTH, FLD_AVG_RATE, FLD_CONST_RATE, FLD_TEMP_LAYERS, FLD_TEMP_NESTED,
    FLD_LEN_SIZE
  } field_id_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  fid;
    logic [31:0] fval;
    logic [1:0]  utype;
    logic [7:0]  ubyte;
    logic        unit_first;
    logic        unit_last;
    logic        ok;
    logic        run_end;
  } parse_result_t;

  class hvcc_scoreboard;
    phase_e        phase;
    logic [4:0]    hdr_idx;
    logic [31:0]   hdr_acc;
    logic [7:0]    arrays_left;
    logic [15:0]   units_left;
    logic [15:0]   bytes_left;
    logic [1:0]    unit_cls;
    parse_result_t expected_q[$];
    parse_result_t run_q[$];
    int unsigned   errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      phase       = PH_HEADER;
      hdr_idx     = '0;
      hdr_acc     = '0;
      arrays_left = '0;
      units_left  = '0;
      bytes_left  = '0;
      unit_cls    = '0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void emit(kind_e k, logic [3:0] fid, logic [31:0] fval, logic [1:0] ut,
                       logic [7:0] ub, logic uf, logic ul, logic ok);
      parse_result_t r;
      r.kind       = k;
      r.fid        = fid;
      r.fval       = fval;
      r.utype      = ut;
      r.ubyte      = ub;
      r.unit_first = uf;
      r.unit_last  = ul;
      r.ok         = ok;
      r.run_end    = 1'b0;
      run_q.insert(run_q.size(), r);
    endfunction

    function void field(field_id_e id, logic [31:0] v);
      emit(KIND_FIELD, id, v, 2'd0, 8'd0, 1'b0, 1'b0, 1'b0);
    endfunction

    function void close_array();
      arrays_left = arrays_left - 8'd1;
      phase = (arrays_left != 0) ? PH_ATYPE : PH_DONE;
    endfunction

    function void close_unit();
      units_left = units_left - 16'd1;
      if (units_left == 0) begin
        close_array();
      end else begin
        phase = PH_LEN_HI;
      end
    endfunction

    // one accepted word: advance the parse and queue what it should produce
    function void note_byte(logic [7:0] b, logic lst);
      logic [5:0] nal;
      run_q.delete();
      case (phase)
        PH_HEADER: begin
          hdr_acc = {hdr_acc[23:0], b};
          case (hdr_idx)
            5'd0: field(FLD_VERSION, 32'(b));
            5'd1: begin
              field(FLD_PROFILE_SPACE, 32'(b[7:6]));
              field(FLD_TIER, 32'(b[5]));
              field(FLD_PROFILE_IDC, 32'(b[4:0]));
            end
            5'd5: field(FLD_COMPAT_FLAGS, hdr_acc);
            5'd12: field(FLD_LEVEL_IDC, 32'(b));
            5'd14: field(FLD_MIN_SEG, 32'(hdr_acc[11:0]));
            5'd15: field(FLD_PARALLELISM, 32'(b[1:0]));
            5'd16: field(FLD_CHROMA_FMT, 32'(b[1:0]));
            5'd17: field(FLD_LUMA_DEPTH, 32'(b[2:0]));
            5'd18: field(FLD_CHROMA_DEPTH, 32'(b[2:0]));
            5'd20: field(FLD_AVG_RATE, 32'(hdr_acc[15:0]));
            5'd21: begin
              field(FLD_CONST_RATE, 32'(b[7:6]));
              field(FLD_TEMP_LAYERS, 32'(b[5:3]));
              field(FLD_TEMP_NESTED, 32'(b[2]));
              field(FLD_LEN_SIZE, 32'(b[1:0]));
            end
            default: ;
          endcase
          // last header byte carries the array count
          if (hdr_idx == HdrLastIdx) begin
            arrays_left = b;
            phase = (b != 0) ? PH_ATYPE : PH_DONE;
            hdr_acc = '0;
          end
          hdr_idx = hdr_idx + 5'd1;
        end
        PH_ATYPE: begin
          nal = b[5:0];
          if (nal >= NalVps && nal <= NalPps) begin
            unit_cls = 2'(nal - NalVps);
          end else begin
            unit_cls = ClassDrop;
          end
          phase = PH_CNT_HI;
        end
        PH_CNT_HI: begin
          units_left = {b, 8'h00};
          phase = PH_CNT_LO;
        end
        PH_CNT_LO: begin
          units_left = {units_left[15:8], b};
          if (units_left == 0) begin
            close_array();
          end else begin
            phase = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          bytes_left = {b, 8'h00};
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          bytes_left = {bytes_left[15:8], b};
          if (bytes_left == 0) begin
            if (unit_cls != ClassDrop) begin
              emit(KIND_EMPTY_UNIT, 4'd0, 32'd0, unit_cls, 8'd0, 1'b0, 1'b0, 1'b0);
            end
            close_unit();
          end else begin
            // bit 0 flags the first payload word of the unit
            hdr_acc = 32'd1;
            phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (unit_cls != ClassDrop) begin
            emit(KIND_UNIT_BYTE, 4'd0, 32'd0, unit_cls, b, hdr_acc[0],
                 bytes_left == 16'd1, 1'b0);
          end
          hdr_acc = '0;
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 0) begin
            close_unit();
          end
        end
        default: ;
      endcase
      if (lst) begin
        emit(KIND_STATUS, 4'd0, 32'd0, 2'd0, 8'd0, 1'b0, 1'b0, phase == PH_DONE);
        clear_state();
      end
      if (run_q.size() > 0) begin
        run_q[run_q.size() - 1].run_end = 1'b1;
      end
      foreach (run_q[i]) begin
        expected_q.insert(expected_q.size(), run_q[i]);
      end
    endfunction

    function void compare(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      end
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d id %0d value %0h",
                 $time, got.kind, got.fid, got.fval);
        return;
      end
      want = expected_q.pop_front();
      compare("result_kind", 32'(want.kind), 32'(got.kind));
      compare("field_id", 32'(want.fid), 32'(got.fid));
      compare("field_value", want.fval, got.fval);
      compare("unit_type", 32'(want.utype), 32'(got.utype));
      compare("unit_byte", 32'(want.ubyte), 32'(got.ubyte));
      compare("unit_first", 32'(want.unit_first), 32'(got.unit_first));
      compare("unit_last", 32'(want.unit_last), 32'(got.unit_last));
      compare("record_ok", 32'(want.ok), 32'(got.ok));
      compare("last_of_run", 32'(want.run_end), 32'(got.run_end));
    endfunction
  endclass

endpackage

// ===== dv/tb_top.sv =====
// testbench top for the hvcC record parser: clock, reset, record stimulus and checks
module tb_top;
  import hcrp_pkg::*;
  import hcrp_tb_pkg::*;

  localparam int unsigned LongHold    = 80;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned TimeLimit   = 2000000;

  typedef enum int unsigned {
    SHAPE_FULL, SHAPE_SHORT, SHAPE_TRUNC, SHAPE_GARBLED
  } shape_e;

  logic clk_i;
  logic rst_ni;

  hcrp_in_if  in_if();
  hcrp_out_if out_if();

  hevc_config_record_parser dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  hvcc_scoreboard sb = new();
  logic [7:0]     rec_q[$];
  bit             quiet;
  bit             hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // input side noted before the output side so same-edge results line up
  always @(posedge clk_i) begin : monitor
    parse_result_t got;
    if (rst_ni && in_if.valid && in_if.ready) begin
      sb.note_byte(in_if.data_byte, in_if.last_byte);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.kind       = kind_e'(out_if.result_kind);
      got.fid        = out_if.field_id;
      got.fval       = out_if.field_value;
      got.utype      = out_if.unit_type;
      got.ubyte      = out_if.unit_byte;
      got.unit_first = out_if.unit_first;
      got.unit_last  = out_if.unit_last;
      got.ok         = out_if.record_ok;
      got.run_end    = out_if.last_of_run;
      sb.check_result(got);
    end
  end

  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // long hold so the result register backs up into the input
        out_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        stall = $urandom_range(1, 15) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #(TimeLimit);
    $display("FAIL");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input logic lst);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= lst;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_record();
    foreach (rec_q[i]) begin
      push_byte(rec_q[i], i == rec_q.size() - 1);
    end
  endtask

  task automatic add_word(input logic [7:0] b);
    rec_q.insert(rec_q.size(), b);
  endtask

  task automatic add_header(input logic [7:0] n_arrays);
    rec_q.delete();
    repeat (22) add_word(8'($urandom));
    add_word(n_arrays);
  endtask

  // upper two bits of the type word are don't-care flags
  task automatic add_array_head(input logic [5:0] nal, input logic [15:0] count);
    add_word({2'($urandom), nal});
    add_word(count[15:8]);
    add_word(count[7:0]);
  endtask

  task automatic add_unit(input logic [15:0] len);
    add_word(len[15:8]);
    add_word(len[7:0]);
    repeat (len) add_word(8'($urandom));
  endtask

  function automatic logic [5:0] random_nal(input bit keep);
    int unsigned t;
    if (keep) begin
      return NalVps + 6'($urandom_range(0, 2));
    end
    t = $urandom_range(0, 60);
    if (t >= 32) begin
      t += 3;
    end
    return 6'(t);
  endfunction

  task automatic build_record(input shape_e shape);
    int unsigned n_arr;
    int unsigned n_units;
    int unsigned keep_len;
    case (shape)
      SHAPE_SHORT: begin
        add_header(8'($urandom));
        keep_len = $urandom_range(1, 22);
        while (rec_q.size() > keep_len) rec_q.delete(rec_q.size() - 1);
      end
      SHAPE_GARBLED: begin
        add_header(8'($urandom_range(1, 255)));
        repeat ($urandom_range(1, 10)) add_word(8'($urandom));
      end
      default: begin
        n_arr = (shape == SHAPE_TRUNC) ? $urandom_range(1, 3) : $urandom_range(0, 3);
        add_header(8'(n_arr));
        repeat (n_arr) begin
          n_units = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2);
          add_array_head(random_nal($urandom_range(0, 3) != 0), 16'(n_units));
          repeat (n_units) add_unit(($urandom_range(0, 4) == 0) ? 16'd0 :
                                    16'($urandom_range(1, 4)));
        end
        if (shape == SHAPE_TRUNC) begin
          keep_len = $urandom_range(24, rec_q.size() - 1);
          while (rec_q.size() > keep_len) rec_q.delete(rec_q.size() - 1);
        end else if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) add_word(8'($urandom));
        end
      end
    endcase
  endtask

  initial begin : stimulus
    rst_ni = 1'b0;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= 8'h00;
    in_if.last_byte <= 1'b0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one-word records at both extremes, then a short record ending on the
    // word that completes four fields
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    for (int i = 0; i < 22; i++) push_byte(8'hFF, i == 21);

    // empty array, zero-length kept and dropped units, dropped type, trailing words,
    // offered while the receiver holds off so the input stalls
    hold_req = 1'b1;
    add_header(8'd4);
    add_array_head(NalVps, 16'd0);
    add_array_head(NalVps + 6'd1, 16'd2);
    add_unit(16'd0);
    add_unit(16'd3);
    add_array_head(NalPps, 16'd1);
    add_unit(16'($urandom_range(1, 4)));
    add_array_head(random_nal(1'b0), 16'd2);
    add_unit(16'd0);
    add_unit(16'd2);
    repeat (2) add_word(8'($urandom));
    send_record();

    // wait for every expected result before going on
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);

    // a record with no arrays, then one cut off inside its arrays with no idling
    build_record(SHAPE_FULL);
    rec_q[22] = 8'd0;
    while (rec_q.size() > 23) rec_q.delete(rec_q.size() - 1);
    send_record();
    quiet = 1'b1;
    build_record(SHAPE_TRUNC);
    send_record();

    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hcrp_pkg.sv
rtl/core/hcrp_if.sv
rtl/core/hcrp_parser.sv
rtl/core/hcrp_serializer.sv
rtl/core/hevc_config_record_parser.sv
dv/hcrp_tb_pkg.sv
dv/tb_top.sv
